@@ hdl/brle8_pkg.sv @@
// shared types, constants and helper functions of the rle8 decoder
package brle8_pkg;

   localparam int MaxSide = 8192;
   localparam int SideW   = 14;
   localparam int AddrW   = 26;
   localparam int PtrW    = 42;
   localparam int RowW    = 14;
   localparam int MulW    = 13;
   localparam int LimitW  = 27;
   localparam int DeltaW  = 23;

   localparam logic signed [PtrW-1:0] PtrMax = 42'sd1099511627776;
   localparam logic signed [PtrW-1:0] PtrMin = -42'sd1099511627776;

   localparam logic [7:0] EscEol   = 8'd0;
   localparam logic [7:0] EscEoi   = 8'd1;
   localparam logic [7:0] EscDelta = 8'd2;

   typedef enum logic [2:0] {
      PH_COUNT,
      PH_RUNVAL,
      PH_ESCAPE,
      PH_DX,
      PH_DY,
      PH_LITERAL,
      PH_PAD
   } phase_type;

   typedef enum logic {
      CSR_WIDTH,
      CSR_HEIGHT
   } csr_index_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       image_start;
   } item_type;

   typedef struct packed {
      logic [AddrW-1:0] write_address;
      logic [7:0]       run_length;
      logic [7:0]       pixel_value;
      logic             out_of_range;
      logic             image_done;
   } result_type;

   typedef struct packed {
      logic [SideW-1:0]  stride;
      logic [SideW-1:0]  height;
      logic [LimitW-1:0] limit;
   } geom_type;

   // clamp a register value into 1..MaxSide
   function automatic logic [SideW-1:0] side_of(input logic [SideW-1:0] v);
      logic [SideW-1:0] r;
      r = v;
      if (v == '0) r = SideW'(1);
      else if (v > SideW'(MaxSide)) r = SideW'(MaxSide);
      return r;
   endfunction

   // saturate a grown pointer sum into the signed pointer range
   function automatic logic signed [PtrW-1:0] sat_ptr(input logic signed [PtrW:0] s);
      logic signed [PtrW-1:0] r;
      r = s[PtrW-1:0];
      if (s > $signed({PtrMax[PtrW-1], PtrMax})) r = PtrMax;
      else if (s < $signed({PtrMin[PtrW-1], PtrMin})) r = PtrMin;
      return r;
   endfunction

endpackage

@@ hdl/brle8_ifs.sv @@
// channel interfaces of the rle8 decoder

interface brle8_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       image_start;
   modport source (output valid, output data_byte, output image_start, input ready);
   modport sink (input valid, input data_byte, input image_start, output ready);
endinterface

interface brle8_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [brle8_pkg::AddrW-1:0]   write_address;
   logic [7:0]                    run_length;
   logic [7:0]                    pixel_value;
   logic                          out_of_range;
   logic                          image_done;
   modport source (output valid, output write_address, output run_length,
                   output pixel_value, output out_of_range, output image_done,
                   input ready);
   modport sink (input valid, input write_address, input run_length,
                 input pixel_value, input out_of_range, input image_done,
                 output ready);
endinterface

interface brle8_csr_if;
   logic                          valid;
   logic                          ready;
   logic                          index;
   logic [brle8_pkg::SideW-1:0]   data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

@@ hdl/brle8_geom.sv @@
// size registers and derived stride, height and buffer limit
module brle8_geom (
   input  logic                  clock,
   input  logic                  reset,
   brle8_csr_if.sink             csr,
   output brle8_pkg::geom_type   geom
);

   logic [brle8_pkg::SideW-1:0]  width_ff, width_in;
   logic [brle8_pkg::SideW-1:0]  height_ff, height_in;
   logic [brle8_pkg::SideW-1:0]  width_used;
   logic [brle8_pkg::SideW:0]    stride_wide;
   logic [2*brle8_pkg::SideW-1:0] area;

   assign csr.ready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr.valid) begin
         unique case (brle8_pkg::csr_index_type'(csr.index))
            brle8_pkg::CSR_WIDTH:  width_in  = csr.data;
            brle8_pkg::CSR_HEIGHT: height_in = csr.data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= brle8_pkg::SideW'(1);
         height_ff <= brle8_pkg::SideW'(1);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // stride is the width rounded up to four bytes
   assign width_used  = brle8_pkg::side_of(width_ff);
   assign stride_wide = ({1'b0, width_used} + (brle8_pkg::SideW+1)'(3))
                        & ~(brle8_pkg::SideW+1)'(3);
   assign geom.stride = stride_wide[brle8_pkg::SideW-1:0];
   assign geom.height = brle8_pkg::side_of(height_ff);
   assign area        = geom.stride * geom.height;
   assign geom.limit  = area[brle8_pkg::LimitW-1:0];

endmodule

@@ hdl/brle8_core.sv @@
// decode state and write pointer update, one byte per step
module brle8_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  brle8_pkg::item_type    item,
   input  brle8_pkg::geom_type    geom,
   output logic                   result_valid,
   output brle8_pkg::result_type  result
);

   localparam int PW = brle8_pkg::PtrW;
   localparam int RW = brle8_pkg::RowW;

   brle8_pkg::phase_type           phase_ff, phase_in;
   logic [7:0]                     run_left_ff, run_left_in;
   logic                           odd_ff, odd_in;
   logic [7:0]                     delta_x_ff, delta_x_in;
   logic signed [PW-1:0]           ptr_ff, ptr_in;
   logic [RW-1:0]                  row_ff, row_in;
   logic                           finished_ff, finished_in;

   brle8_pkg::phase_type           phase_eff;
   logic                           finished_eff;
   logic [7:0]                     b;
   logic [RW:0]                    mul_sel;
   logic [brle8_pkg::MulW-1:0]     mul_opnd;
   logic [brle8_pkg::SideW+brle8_pkg::MulW-1:0] row_base;
   logic [brle8_pkg::SideW+7:0]    dy_step;
   logic signed [brle8_pkg::DeltaW-1:0] addend;
   logic signed [PW:0]             ptr_sum;
   logic signed [PW:0]             run_end;
   logic [7:0]                     emit_len;
   logic [RW:0]                    row_next;
   logic [RW:0]                    row_dy;
   logic [7:0]                     lit_left;

   assign b = item.data_byte;

   // start of image restarts everything; that byte itself is decoded in the count phase
   assign phase_eff    = item.image_start ? brle8_pkg::PH_COUNT : phase_ff;
   assign finished_eff = item.image_start ? 1'b0 : finished_ff;

   // one multiplier serves image start (last row) and end-of-line (next row up)
   assign mul_sel  = item.image_start ?
                     ({1'b0, geom.height} - (RW+1)'(1)) :
                     ({1'b0, geom.height} - (RW+1)'(2) - {1'b0, row_ff});
   assign mul_opnd = mul_sel[brle8_pkg::MulW-1:0];
   assign row_base = geom.stride * mul_opnd;

   assign dy_step  = b * geom.stride;
   assign row_next = {1'b0, row_ff} + (RW+1)'(1);
   assign row_dy   = {1'b0, row_ff} + (RW+1)'(b);
   assign lit_left = (run_left_ff != 8'd0) ? run_left_ff - 8'd1 : run_left_ff;

   // pixels covered by the command this byte makes
   assign emit_len = (phase_eff == brle8_pkg::PH_RUNVAL)  ? run_left_ff :
                     (phase_eff == brle8_pkg::PH_LITERAL) ? 8'd1 : 8'd0;

   always_comb begin
      addend = '0;
      case (phase_ff)
         brle8_pkg::PH_RUNVAL:  addend = brle8_pkg::DeltaW'(run_left_ff);
         brle8_pkg::PH_LITERAL: addend = brle8_pkg::DeltaW'(1);
         brle8_pkg::PH_DY:      addend = $signed(brle8_pkg::DeltaW'(delta_x_ff))
                                         - $signed(brle8_pkg::DeltaW'(dy_step));
         default:               addend = '0;
      endcase
   end

   assign ptr_sum = {ptr_ff[PW-1], ptr_ff} + (PW+1)'(addend);

   // out-of-range check on the pointer before it moves
   assign run_end = {ptr_ff[PW-1], ptr_ff} + $signed((PW+1)'(emit_len));

   always_comb begin
      phase_in     = phase_eff;
      run_left_in  = item.image_start ? 8'd0 : run_left_ff;
      odd_in       = item.image_start ? 1'b0 : odd_ff;
      delta_x_in   = item.image_start ? 8'd0 : delta_x_ff;
      row_in       = item.image_start ? '0 : row_ff;
      finished_in  = finished_eff;
      ptr_in       = item.image_start ? PW'(row_base) : ptr_ff;
      result_valid = 1'b0;
      result       = '0;

      if (!finished_eff) begin
         unique case (phase_eff)
            brle8_pkg::PH_COUNT: begin
               if (b != 8'd0) begin
                  run_left_in = b;
                  phase_in    = brle8_pkg::PH_RUNVAL;
               end else begin
                  phase_in    = brle8_pkg::PH_ESCAPE;
               end
            end
            brle8_pkg::PH_RUNVAL: begin
               result_valid = 1'b1;
               ptr_in       = brle8_pkg::sat_ptr(ptr_sum);
               phase_in     = brle8_pkg::PH_COUNT;
            end
            brle8_pkg::PH_ESCAPE: begin
               phase_in = brle8_pkg::PH_COUNT;
               case (b)
                  brle8_pkg::EscEol: begin
                     if (row_next >= {1'b0, geom.height}) begin
                        finished_in       = 1'b1;
                        result_valid      = 1'b1;
                        result.image_done = 1'b1;
                     end else begin
                        row_in = row_next[RW-1:0];
                        ptr_in = PW'(row_base);
                     end
                  end
                  brle8_pkg::EscEoi: begin
                     finished_in       = 1'b1;
                     result_valid      = 1'b1;
                     result.image_done = 1'b1;
                  end
                  brle8_pkg::EscDelta: phase_in = brle8_pkg::PH_DX;
                  default: begin
                     run_left_in = b;
                     odd_in      = b[0];
                     phase_in    = brle8_pkg::PH_LITERAL;
                  end
               endcase
            end
            brle8_pkg::PH_DX: begin
               delta_x_in = b;
               phase_in   = brle8_pkg::PH_DY;
            end
            brle8_pkg::PH_DY: begin
               ptr_in   = brle8_pkg::sat_ptr(ptr_sum);
               row_in   = (row_dy > {1'b0, geom.height}) ? geom.height : row_dy[RW-1:0];
               phase_in = brle8_pkg::PH_COUNT;
            end
            brle8_pkg::PH_LITERAL: begin
               result_valid = 1'b1;
               ptr_in       = brle8_pkg::sat_ptr(ptr_sum);
               run_left_in  = lit_left;
               if (lit_left == 8'd0) begin
                  phase_in = odd_ff ? brle8_pkg::PH_PAD : brle8_pkg::PH_COUNT;
               end
            end
            brle8_pkg::PH_PAD: phase_in = brle8_pkg::PH_COUNT;
            default:           phase_in = brle8_pkg::PH_COUNT;
         endcase

         if (result_valid && !result.image_done) begin
            result.write_address = ptr_ff[brle8_pkg::AddrW-1:0];
            result.run_length    = emit_len;
            result.pixel_value   = b;
            result.out_of_range  = ptr_ff[PW-1] ||
                                   (run_end > $signed((PW+1)'(geom.limit)));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= brle8_pkg::PH_COUNT;
         run_left_ff <= 8'd0;
         odd_ff      <= 1'b0;
         delta_x_ff  <= 8'd0;
         ptr_ff      <= '0;
         row_ff      <= '0;
         finished_ff <= 1'b0;
      end else if (step) begin
         phase_ff    <= phase_in;
         run_left_ff <= run_left_in;
         odd_ff      <= odd_in;
         delta_x_ff  <= delta_x_in;
         ptr_ff      <= ptr_in;
         row_ff      <= row_in;
         finished_ff <= finished_in;
      end
   end

endmodule

@@ hdl/brle8_out.sv @@
// result register in front of the rsp channel
module brle8_out (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  brle8_pkg::result_type  result,
   output logic                   advance,
   brle8_rsp_if.source            rsp
);

   logic                   valid_ff, valid_in;
   brle8_pkg::result_type  data_ff;

   // the stage may move on when the register is empty or drains this cycle
   assign advance  = !valid_ff || rsp.ready;
   assign valid_in = advance ? load : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && load) begin
         data_ff <= result;
      end
   end

   assign rsp.valid         = valid_ff;
   assign rsp.write_address = data_ff.write_address;
   assign rsp.run_length    = data_ff.run_length;
   assign rsp.pixel_value   = data_ff.pixel_value;
   assign rsp.out_of_range  = data_ff.out_of_range;
   assign rsp.image_done    = data_ff.image_done;

endmodule

@@ hdl/bmp_rle8_decoder.sv @@
// top level of the bmp rle8 decoder: frame-buffer write commands from an rle8 byte stream
//
// req carries one byte of the compressed stream per transfer; image_start on a byte
// restarts decoding with that byte as the first of a new image (pointer at the last
// buffer row, which is the bottom row of the image).
// rsp carries at most one write command per byte: address, run length, pixel value,
// an out-of-range flag for the writer, and image_done on end of image.
// csr sets the row width in pixels (index 0) and the row count (index 1); it is always
// ready and should only be written while no byte is in flight.
// a byte accepted on req goes into the input register and is decoded from there into the
// result register, whose command is valid on rsp; bytes that make no command leave nothing.
// throughput: one byte per clock while rsp does not stall, set by the single decode stage
// between the input register and the result register, where the row-address multiply sits.
// when rsp stalls, the result register holds and the input register keeps one more
// byte, after which req.ready drops; nothing is lost or repeated.
// reset clears the decoder to wait for a count byte with pointer and row at zero and
// sets both size registers to one; there is no clearing pass.
module bmp_rle8_decoder (
   input  logic          clock,
   input  logic          reset,
   brle8_req_if.sink     req,
   brle8_rsp_if.source   rsp,
   brle8_csr_if.sink     csr
);

   // input register
   logic                   in_valid_ff, in_valid_in;
   brle8_pkg::item_type    in_item_ff;

   logic                   advance;
   logic                   step;
   logic                   core_valid;
   brle8_pkg::result_type  core_result;
   brle8_pkg::geom_type    geom;

   // a byte is decoded when the input register holds one and the result side can take it
   assign step      = in_valid_ff && advance;
   assign req.ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req.valid && req.ready) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // payload only loads on a transfer
   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_item_ff.data_byte   <= req.data_byte;
         in_item_ff.image_start <= req.image_start;
      end
   end

   // size registers and derived geometry
   brle8_geom u_geom (
      .clock (clock),
      .reset (reset),
      .csr   (csr),
      .geom  (geom)
   );

   // decode stage
   brle8_core u_core (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .item         (in_item_ff),
      .geom         (geom),
      .result_valid (core_valid),
      .result       (core_result)
   );

   // result register
   brle8_out u_out (
      .clock   (clock),
      .reset   (reset),
      .load    (step && core_valid),
      .result  (core_result),
      .advance (advance),
      .rsp     (rsp)
   );

`ifndef SYNTHESIS
   // a done command carries no write
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.image_done |-> rsp.write_address == '0 &&
         rsp.run_length == 8'd0 && rsp.pixel_value == 8'd0 && !rsp.out_of_range)
      else $error("done command carries write fields");

   // an ordinary write always covers at least one pixel
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.image_done |-> rsp.run_length != 8'd0)
      else $error("write command with zero length");

   // back-pressure on req only comes from a full input register and a stalled rsp
   assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> in_valid_ff && rsp.valid && !rsp.ready)
      else $error("req stalled without rsp back-pressure");

   // a byte held in the input register is decoded as soon as rsp frees up
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !rsp.valid |-> step)
      else $error("held byte not decoded");
`endif

endmodule
